@@ hdl/ecd_pkg.sv @@
// Shared types, constants and tables for the epoch-milliseconds to civil date converter.
package ecd_pkg;

    localparam int unsigned MS_W     = 48;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned MILLI_W  = 10;

    localparam longint MS_PER_DAY    = 86400000;
    localparam longint MS_PER_HOUR   = 3600000;
    localparam longint MS_PER_MINUTE = 60000;
    localparam longint MS_PER_SECOND = 1000;
    localparam longint SHIFT_DAYS    = 719468;
    localparam longint DAYS_PER_ERA  = 146097;
    localparam longint DAYS_PER_4Y   = 1460;
    localparam longint DAYS_PER_CENT = 36524;
    localparam longint DAYS_PER_YEAR = 365;
    localparam longint MP_DAYS       = 153;
    localparam longint YEARS_PER_ERA = 400;
    localparam longint YEARS_PER_CENT = 100;
    localparam int unsigned MP_JAN   = 10;

    // day split: MS_PER_DAY = 2^LO_W * DS_DIV
    localparam int unsigned LO_W       = 10;
    localparam longint      DS_DIV     = MS_PER_DAY / (64'd1 << LO_W);
    localparam int unsigned DS_Y_W     = MS_W - LO_W + 1;
    localparam int unsigned DS_DIGIT_W = 13;
    localparam int unsigned DS_DIGITS  = DS_Y_W / DS_DIGIT_W;
    localparam int unsigned DS_REM_W   = 17;
    localparam int unsigned DS_SHIFT   = DS_REM_W + DS_DIGIT_W + DS_REM_W;
    localparam int unsigned DS_RECIP_W = 31;
    localparam logic [DS_RECIP_W-1:0] DS_RECIP =
        DS_RECIP_W'(((64'd1 << DS_SHIFT) + 64'(DS_DIV) - 64'd1) / 64'(DS_DIV));
    // day offset making the shifted input non-negative
    localparam longint DAY_BIAS = (64'd1 << (MS_W - 1)) / 64'(MS_PER_DAY) + 64'd1;
    localparam logic [DS_Y_W-1:0] DS_BIAS = DS_Y_W'(64'(DAY_BIAS) * 64'(DS_DIV));

    localparam int unsigned DAYS_W = 22;
    localparam int unsigned REM_W  = DS_REM_W + LO_W;

    // era offset keeps the shifted day count non-negative
    localparam longint ERA_BIAS = 7;
    localparam logic [DAYS_W-1:0] Z_BIAS =
        DAYS_W'(64'(ERA_BIAS * DAYS_PER_ERA + SHIFT_DAYS) - 64'(DAY_BIAS));

    localparam int unsigned ERA_W      = 5;
    localparam int unsigned ERA_SHIFT  = 40;
    localparam logic [22:0] ERA_RECIP  =
        23'(((64'd1 << ERA_SHIFT) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));
    localparam int unsigned DOE_W      = 18;
    localparam int unsigned Q4_SHIFT   = 29;
    localparam logic [18:0] Q4_RECIP   =
        19'(((64'd1 << Q4_SHIFT) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));
    localparam int unsigned YOE_W      = 9;
    localparam int unsigned YR_SHIFT   = 27;
    localparam logic [18:0] YR_RECIP   =
        19'(((64'd1 << YR_SHIFT) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));
    localparam int unsigned MP_SHIFT   = 19;
    localparam logic [11:0] MP_RECIP   =
        12'(((64'd1 << MP_SHIFT) + 64'(MP_DAYS) - 64'd1) / 64'(MP_DAYS));

    // time of day: hour = (rem >> 7) / 28125, minute = (x >> 5) / 1875, second = (x >> 3) / 125
    localparam int unsigned H_PRE      = 7;
    localparam int unsigned H_SHIFT    = 35;
    localparam longint      H_DIV      = MS_PER_HOUR / (64'd1 << H_PRE);
    localparam logic [20:0] H_RECIP    =
        21'(((64'd1 << H_SHIFT) + 64'(H_DIV) - 64'd1) / 64'(H_DIV));
    localparam int unsigned M_PRE      = 5;
    localparam int unsigned M_SHIFT    = 28;
    localparam longint      M_DIV      = MS_PER_MINUTE / (64'd1 << M_PRE);
    localparam logic [17:0] M_RECIP    =
        18'(((64'd1 << M_SHIFT) + 64'(M_DIV) - 64'd1) / 64'(M_DIV));
    localparam int unsigned S_PRE      = 3;
    localparam int unsigned S_SHIFT    = 20;
    localparam longint      S_DIV      = MS_PER_SECOND / (64'd1 << S_PRE);
    localparam logic [13:0] S_RECIP    =
        14'(((64'd1 << S_SHIFT) + 64'(S_DIV) - 64'd1) / 64'(S_DIV));

    localparam int unsigned DS_STAGES    = 1 + 2 * DS_DIGITS;
    localparam int unsigned CIVIL_STAGES = 9;
    localparam int unsigned TOD_STAGES   = 6;
    localparam int unsigned ALIGN_STAGES = CIVIL_STAGES - TOD_STAGES;

    typedef struct packed {
        logic              valid;
        logic [DAYS_W-1:0] days;
        logic [REM_W-1:0]  rem;
    } days_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MILLI_W-1:0]  millisecond;
    } tod_t;

    // first day of a March-based month within the year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/ecd_day_split.sv @@
// Pipelined floor division of the millisecond count into day number and time-of-day remainder.
module ecd_day_split (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [ecd_pkg::MS_W-1:0]     epoch_millis,
    output ecd_pkg::days_t                      days_out
);
    localparam int unsigned ND = ecd_pkg::DS_DIGITS;
    localparam int unsigned DW = ecd_pkg::DS_DIGIT_W;
    localparam int unsigned YW = ecd_pkg::DS_Y_W;
    localparam int unsigned RW = ecd_pkg::DS_REM_W;
    localparam int unsigned LW = ecd_pkg::LO_W;
    localparam int unsigned VW = RW + DW;
    localparam int unsigned PW = VW + ecd_pkg::DS_RECIP_W;
    localparam int unsigned MW = ecd_pkg::MS_W;

    logic            in_valid_reg;
    logic [YW-1:0]   y_reg;
    logic [YW-1:0]   y_next;
    logic [LW-1:0]   lo_reg;

    logic [ND-1:0]   mv_reg;
    logic [ND-1:0]   rv_reg;
    logic [VW-1:0]   mval_reg [ND];
    logic [VW-1:0]   mval_next [ND];
    logic [DW-1:0]   mq_reg [ND];
    logic [DW-1:0]   mq_next [ND];
    logic [YW-1:0]   my_reg [ND];
    logic [YW-1:0]   ry_reg [ND];
    logic [LW-1:0]   mlo_reg [ND];
    logic [LW-1:0]   rlo_reg [ND];
    logic [YW-1:0]   macc_reg [ND];
    logic [YW-1:0]   racc_reg [ND];
    logic [YW-1:0]   racc_next [ND];
    logic [RW-1:0]   rr_reg [ND];
    logic [RW-1:0]   rr_next [ND];

    logic [ND-1:0]   src_valid;
    logic [YW-1:0]   src_y [ND];
    logic [YW-1:0]   src_acc [ND];
    logic [LW-1:0]   src_lo [ND];
    logic [RW-1:0]   src_r [ND];
    logic [PW-1:0]   prod [ND];

    // offset by a whole number of days so the dividend is non-negative
    assign y_next = {epoch_millis[MW-1], epoch_millis[MW-1:LW]} + ecd_pkg::DS_BIAS;

    always_comb
    begin
        src_valid[0] = in_valid_reg;
        src_y[0]     = y_reg;
        src_lo[0]    = lo_reg;
        src_r[0]     = '0;
        src_acc[0]   = '0;
        for (int k = 1; k < ND; k++)
        begin
            src_valid[k] = rv_reg[k-1];
            src_y[k]     = ry_reg[k-1];
            src_lo[k]    = rlo_reg[k-1];
            src_r[k]     = rr_reg[k-1];
            src_acc[k]   = racc_reg[k-1];
        end
        for (int k = 0; k < ND; k++)
        begin
            mval_next[k] = {src_r[k], src_y[k][YW-1-DW*k -: DW]};
            prod[k]      = PW'(mval_next[k]) * PW'(ecd_pkg::DS_RECIP);
            mq_next[k]   = prod[k][ecd_pkg::DS_SHIFT +: DW];
            rr_next[k]   = RW'(mval_reg[k] - VW'(mq_reg[k]) * VW'(ecd_pkg::DS_DIV));
            racc_next[k] = {macc_reg[k][YW-DW-1:0], mq_reg[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mv_reg       <= '0;
            rv_reg       <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid;
            mv_reg       <= src_valid;
            rv_reg       <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg  <= y_next;
        lo_reg <= epoch_millis[LW-1:0];
        for (int k = 0; k < ND; k++)
        begin
            mval_reg[k] <= mval_next[k];
            mq_reg[k]   <= mq_next[k];
            my_reg[k]   <= src_y[k];
            mlo_reg[k]  <= src_lo[k];
            macc_reg[k] <= src_acc[k];
            rr_reg[k]   <= rr_next[k];
            racc_reg[k] <= racc_next[k];
            ry_reg[k]   <= my_reg[k];
            rlo_reg[k]  <= mlo_reg[k];
        end
    end

    assign days_out.valid = rv_reg[ND-1];
    assign days_out.days  = racc_reg[ND-1][ecd_pkg::DAYS_W-1:0];
    assign days_out.rem   = {rr_reg[ND-1], rlo_reg[ND-1]};

endmodule

@@ hdl/ecd_tod.sv @@
// Pipelined split of the day remainder into hour, minute, second and millisecond.
module ecd_tod (
    input  logic                           clk,
    input  logic [ecd_pkg::REM_W-1:0]      rem,
    output ecd_pkg::tod_t                  tod
);
    localparam int unsigned RMW = ecd_pkg::REM_W;
    localparam int unsigned HW  = ecd_pkg::HOUR_W;
    localparam int unsigned NW  = ecd_pkg::MINUTE_W;
    localparam int unsigned SW  = ecd_pkg::SECOND_W;
    localparam int unsigned LW  = ecd_pkg::MILLI_W;
    localparam int unsigned R1W = 22;
    localparam int unsigned R2W = 16;
    localparam int unsigned HPW = 41;
    localparam int unsigned MPW = 35;
    localparam int unsigned SPW = 27;

    logic [HPW-1:0] h_prod;
    logic [MPW-1:0] m_prod;
    logic [SPW-1:0] s_prod;

    logic [HW-1:0]  h1_reg;
    logic [RMW-1:0] rem1_reg;
    logic [HW-1:0]  h2_reg;
    logic [R1W-1:0] rest2_reg;
    logic [HW-1:0]  h3_reg;
    logic [NW-1:0]  n3_reg;
    logic [R1W-1:0] rest3_reg;
    logic [HW-1:0]  h4_reg;
    logic [NW-1:0]  n4_reg;
    logic [R2W-1:0] rest4_reg;
    logic [HW-1:0]  h5_reg;
    logic [NW-1:0]  n5_reg;
    logic [SW-1:0]  s5_reg;
    logic [R2W-1:0] rest5_reg;
    ecd_pkg::tod_t  tod_reg;
    ecd_pkg::tod_t  tod_next;

    assign h_prod = HPW'(rem[RMW-1:ecd_pkg::H_PRE]) * HPW'(ecd_pkg::H_RECIP);
    assign m_prod = MPW'(rest2_reg[R1W-1:ecd_pkg::M_PRE]) * MPW'(ecd_pkg::M_RECIP);
    assign s_prod = SPW'(rest4_reg[R2W-1:ecd_pkg::S_PRE]) * SPW'(ecd_pkg::S_RECIP);

    always_comb
    begin
        tod_next.hour        = h5_reg;
        tod_next.minute      = n5_reg;
        tod_next.second      = s5_reg;
        tod_next.millisecond = LW'(rest5_reg - R2W'(s5_reg) * R2W'(ecd_pkg::MS_PER_SECOND));
    end

    always_ff @(posedge clk)
    begin
        h1_reg    <= h_prod[ecd_pkg::H_SHIFT +: HW];
        rem1_reg  <= rem;
        h2_reg    <= h1_reg;
        rest2_reg <= R1W'(rem1_reg - RMW'(h1_reg) * RMW'(ecd_pkg::MS_PER_HOUR));
        h3_reg    <= h2_reg;
        n3_reg    <= m_prod[ecd_pkg::M_SHIFT +: NW];
        rest3_reg <= rest2_reg;
        h4_reg    <= h3_reg;
        n4_reg    <= n3_reg;
        rest4_reg <= R2W'(rest3_reg - R1W'(n3_reg) * R1W'(ecd_pkg::MS_PER_MINUTE));
        h5_reg    <= h4_reg;
        n5_reg    <= n4_reg;
        s5_reg    <= s_prod[ecd_pkg::S_SHIFT +: SW];
        rest5_reg <= rest4_reg;
        tod_reg   <= tod_next;
    end

    assign tod = tod_reg;

endmodule

@@ hdl/ecd_civil.sv @@
// Pipelined civil-from-days conversion of the shifted day number into year, month and day.
module ecd_civil (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ecd_pkg::days_t                        days_in,
    output logic                                  out_valid,
    output logic signed [ecd_pkg::YEAR_W-1:0]     year,
    output logic [ecd_pkg::MONTH_W-1:0]           month,
    output logic [ecd_pkg::DAY_W-1:0]             day
);
    localparam int unsigned NS  = ecd_pkg::CIVIL_STAGES;
    localparam int unsigned ZW  = ecd_pkg::DAYS_W;
    localparam int unsigned EW  = ecd_pkg::ERA_W;
    localparam int unsigned OW  = ecd_pkg::DOE_W;
    localparam int unsigned YOW = ecd_pkg::YOE_W;
    localparam int unsigned YW  = ecd_pkg::YEAR_W;
    localparam int unsigned MW  = ecd_pkg::MONTH_W;
    localparam int unsigned DYW = ecd_pkg::DAY_W;
    localparam int unsigned EPW = 45;
    localparam int unsigned QPW = 37;
    localparam int unsigned MPW = 23;
    localparam int unsigned DOYW = 9;
    localparam int unsigned NUMW = 11;

    logic [NS-1:0]   vld_reg;

    logic [ZW-1:0]   z1_reg;
    logic [ZW-1:0]   z2_reg;
    logic [EW-1:0]   era2_reg;
    logic [EW-1:0]   era3_reg;
    logic [OW-1:0]   doe3_reg;
    logic [EW-1:0]   era4_reg;
    logic [OW-1:0]   doe4_reg;
    logic [6:0]      a4_reg;
    logic [2:0]      b4_reg;
    logic            c4_reg;
    logic [EW-1:0]   era5_reg;
    logic [OW-1:0]   doe5_reg;
    logic [OW-1:0]   t5_reg;
    logic [EW-1:0]   era6_reg;
    logic [OW-1:0]   doe6_reg;
    logic [YOW-1:0]  yoe6_reg;
    logic [EW-1:0]   era7_reg;
    logic [YOW-1:0]  yoe7_reg;
    logic [DOYW-1:0] doy7_reg;
    logic [EW-1:0]   era8_reg;
    logic [YOW-1:0]  yoe8_reg;
    logic [DOYW-1:0] doy8_reg;
    logic [3:0]      mp8_reg;
    logic signed [YW-1:0] year_reg;
    logic signed [YW-1:0] year_next;
    logic [MW-1:0]   month_reg;
    logic [MW-1:0]   month_next;
    logic [DYW-1:0]  day_reg;
    logic [DYW-1:0]  day_next;

    logic [EPW-1:0]  era_prod;
    logic [QPW-1:0]  a_prod;
    logic [2:0]      b_val;
    logic [QPW-1:0]  yoe_prod;
    logic [1:0]      cent;
    logic [OW-1:0]   yday_base;
    logic [NUMW-1:0] mp_num;
    logic [MPW-1:0]  mp_prod;
    logic signed [YW-1:0] era_s;
    logic            early;

    always_comb
    begin
        era_prod = EPW'(z1_reg) * EPW'(ecd_pkg::ERA_RECIP);
        a_prod   = QPW'(doe3_reg) * QPW'(ecd_pkg::Q4_RECIP);
        b_val    = 3'(doe3_reg >= OW'(ecd_pkg::DAYS_PER_CENT))
                 + 3'(doe3_reg >= OW'(2 * ecd_pkg::DAYS_PER_CENT))
                 + 3'(doe3_reg >= OW'(3 * ecd_pkg::DAYS_PER_CENT))
                 + 3'(doe3_reg >= OW'(4 * ecd_pkg::DAYS_PER_CENT));
        yoe_prod = QPW'(t5_reg) * QPW'(ecd_pkg::YR_RECIP);
        cent     = 2'(yoe6_reg >= YOW'(ecd_pkg::YEARS_PER_CENT))
                 + 2'(yoe6_reg >= YOW'(2 * ecd_pkg::YEARS_PER_CENT))
                 + 2'(yoe6_reg >= YOW'(3 * ecd_pkg::YEARS_PER_CENT));
        yday_base = OW'(yoe6_reg) * OW'(ecd_pkg::DAYS_PER_YEAR)
                  + OW'(yoe6_reg >> 2) - OW'(cent);
        mp_num   = NUMW'(doy7_reg) * NUMW'(5) + NUMW'(2);
        mp_prod  = MPW'(mp_num) * MPW'(ecd_pkg::MP_RECIP);

        early      = (mp8_reg >= 4'(ecd_pkg::MP_JAN));
        month_next = early ? MW'(mp8_reg - 4'(9)) : MW'(mp8_reg + 4'(3));
        day_next   = DYW'(doy8_reg - ecd_pkg::month_start(mp8_reg) + DOYW'(1));
        era_s      = $signed(YW'(era8_reg)) - $signed(YW'(ecd_pkg::ERA_BIAS));
        year_next  = era_s * $signed(YW'(ecd_pkg::YEARS_PER_ERA))
                   + $signed(YW'(yoe8_reg)) + $signed(YW'(early));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-2:0], days_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        z1_reg    <= days_in.days + ecd_pkg::Z_BIAS;
        z2_reg    <= z1_reg;
        era2_reg  <= era_prod[ecd_pkg::ERA_SHIFT +: EW];
        era3_reg  <= era2_reg;
        doe3_reg  <= OW'(z2_reg - ZW'(era2_reg) * ZW'(ecd_pkg::DAYS_PER_ERA));
        era4_reg  <= era3_reg;
        doe4_reg  <= doe3_reg;
        a4_reg    <= a_prod[ecd_pkg::Q4_SHIFT +: 7];
        b4_reg    <= b_val;
        c4_reg    <= (doe3_reg == OW'(ecd_pkg::DAYS_PER_ERA - 1));
        era5_reg  <= era4_reg;
        doe5_reg  <= doe4_reg;
        t5_reg    <= doe4_reg - OW'(a4_reg) + OW'(b4_reg) - OW'(c4_reg);
        era6_reg  <= era5_reg;
        doe6_reg  <= doe5_reg;
        yoe6_reg  <= yoe_prod[ecd_pkg::YR_SHIFT +: YOW];
        era7_reg  <= era6_reg;
        yoe7_reg  <= yoe6_reg;
        doy7_reg  <= DOYW'(doe6_reg - yday_base);
        era8_reg  <= era7_reg;
        yoe8_reg  <= yoe7_reg;
        doy8_reg  <= doy7_reg;
        mp8_reg   <= mp_prod[ecd_pkg::MP_SHIFT +: 4];
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
    end

    assign out_valid = vld_reg[NS-1];
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;

endmodule

@@ hdl/epoch_ms_to_civil_date_core.sv @@
// Top level: signed epoch milliseconds to proleptic Gregorian date and time of day.
//
// Fully pipelined: a transaction may start on every clock and busy stays low. Each result
// appears for one cycle with done high after 7 stages of reciprocal long division by
// the day length (three 13-bit digits, multiply then subtract) and 9 stages of the
// era / year / month breakdown; the hour to millisecond split runs alongside and is
// delayed to match. Results cannot be held off and arrive in order.
module epoch_ms_to_civil_date_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [ecd_pkg::MS_W-1:0]        epoch_millis,
    output logic                                   done,
    output logic signed [ecd_pkg::YEAR_W-1:0]      year,
    output logic [ecd_pkg::MONTH_W-1:0]            month,
    output logic [ecd_pkg::DAY_W-1:0]              day,
    output logic [ecd_pkg::HOUR_W-1:0]             hour,
    output logic [ecd_pkg::MINUTE_W-1:0]           minute,
    output logic [ecd_pkg::SECOND_W-1:0]           second,
    output logic [ecd_pkg::MILLI_W-1:0]            millisecond
);
    localparam int unsigned NA = ecd_pkg::ALIGN_STAGES;

    ecd_pkg::days_t days;
    ecd_pkg::tod_t  tod;
    ecd_pkg::tod_t  tod_dly_reg [NA];

    assign busy = 1'b0;

    ecd_day_split u_day_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .epoch_millis (epoch_millis),
        .days_out     (days)
    );

    ecd_tod u_tod (
        .clk (clk),
        .rem (days.rem),
        .tod (tod)
    );

    ecd_civil u_civil (
        .clk       (clk),
        .rst_n     (rst_n),
        .days_in   (days),
        .out_valid (done),
        .year      (year),
        .month     (month),
        .day       (day)
    );

    always_ff @(posedge clk)
    begin
        tod_dly_reg[0] <= tod;
        for (int k = 1; k < NA; k++)
        begin
            tod_dly_reg[k] <= tod_dly_reg[k-1];
        end
    end

    assign hour        = tod_dly_reg[NA-1].hour;
    assign minute      = tod_dly_reg[NA-1].minute;
    assign second      = tod_dly_reg[NA-1].second;
    assign millisecond = tod_dly_reg[NA-1].millisecond;

endmodule
